@@ rtl/dhte_pkg.sv @@
// Shared types and constants for the double hash table engine.
// No dependencies; imported by every module of the block.
package dhte_pkg;

    // Default sizes for the top level parameters
    localparam int DEF_TABLE_SLOTS = 1021;
    localparam int DEF_KEY_BITS    = 64;
    localparam int DEF_VALUE_BITS  = 32;

    // Fixed word layout of the input stream
    localparam int KEY_IN_W  = 64;
    localparam int HASH_W    = 64;
    localparam int VAL_IN_W  = 32;
    localparam int KEY_LSB   = 0;
    localparam int HP_LSB    = 64;
    localparam int HS_LSB    = 128;
    localparam int VAL_LSB   = 192;
    localparam int S_DATA_W  = 224;

    // Fixed word layout of the result stream
    localparam int STATUS_W  = 3;
    localparam int FOUND_W   = 32;
    localparam int SLOT_W    = 10;
    localparam int OCC_W     = 10;
    localparam int M_DATA_W  = 56;

    // Hash reduction works one digit per cycle
    localparam int DIGIT_W   = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_PRESENT  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    localparam logic CMD_SEARCH = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Control group from the sequencer to the slot memory
    typedef struct packed {
        logic rd_en;      // read key, value and valid bit at addr
        logic kv_we;      // write key and value at addr
        logic vld_we;     // write valid bit at addr
        logic vld_wdata;  // valid bit to write
    } ram_ctrl_t;

endpackage

@@ rtl/dhte_modred.sv @@
// Iterative reduction of a 64-bit hash modulo the slot count.
// Depends on dhte_pkg; one 4-bit digit is folded in per cycle.
module dhte_modred
    import dhte_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [HASH_W-1:0]                operand,
    output logic                             done,
    output logic [$clog2(TABLE_SLOTS)-1:0]   result
);

    localparam int RW     = $clog2(TABLE_SLOTS);
    localparam int TW     = RW + DIGIT_W;
    localparam int DIGITS = HASH_W / DIGIT_W;
    localparam int CW     = $clog2(DIGITS);
    localparam logic [TW-1:0] S_T = TW'(TABLE_SLOTS);

    logic [HASH_W-1:0] opnd_reg, opnd_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TW-1:0]     fold;

    // remainder*16 + digit is below 16*S: strip 8S, 4S, 2S, S in turn
    always_comb begin
        fold = {rem_reg, opnd_reg[HASH_W-1 -: DIGIT_W]};
        for (int k = DIGIT_W - 1; k >= 0; k--) begin
            if (fold >= (S_T << k)) begin
                fold = fold - (S_T << k);
            end
        end
    end

    always_comb begin
        opnd_next = opnd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            opnd_next = operand;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            opnd_next = opnd_reg << DIGIT_W;
            rem_next  = fold[RW-1:0];
            cnt_next  = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DIGITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        opnd_reg <= opnd_next;
        rem_reg  <= rem_next;
    end

    assign done   = done_reg;
    assign result = rem_reg;

endmodule

@@ rtl/dhte_slot_ram.sv @@
// Slot storage: key, value and valid bit per slot, one shared address.
// Depends on dhte_pkg for the control struct; read data is registered.
module dhte_slot_ram
    import dhte_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic                             aclk,
    input  ram_ctrl_t                        ctrl,
    input  logic [$clog2(TABLE_SLOTS)-1:0]   addr,
    input  logic [KEY_BITS-1:0]              wr_key,
    input  logic [VALUE_BITS-1:0]            wr_value,
    output logic [KEY_BITS-1:0]              rd_key,
    output logic [VALUE_BITS-1:0]            rd_value,
    output logic                             rd_valid
);

    logic [KEY_BITS-1:0]   key_mem   [TABLE_SLOTS];
    logic [VALUE_BITS-1:0] value_mem [TABLE_SLOTS];
    logic                  valid_mem [TABLE_SLOTS];

    always_ff @(posedge aclk) begin
        if (ctrl.kv_we) begin
            key_mem[addr]   <= wr_key;
            value_mem[addr] <= wr_value;
        end
        if (ctrl.rd_en) begin
            rd_key   <= key_mem[addr];
            rd_value <= value_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.vld_we) begin
            valid_mem[addr] <= ctrl.vld_wdata;
        end
        if (ctrl.rd_en) begin
            rd_valid <= valid_mem[addr];
        end
    end

endmodule

@@ rtl/double_hash_table_engine_core.sv @@
// Double hash table engine: open-addressing key/value table, top level.
// Depends on dhte_pkg, dhte_modred and dhte_slot_ram.
//
// Each input word carries a search or insert command (tuser), a key, two
// precomputed hashes and a value. The engine reduces the first hash modulo
// TABLE_SLOTS to get the start slot and the second to get the probe stride,
// then walks slot (h0 + i*h1) mod TABLE_SLOTS until it meets an empty slot
// or the key, or has probed TABLE_SLOTS slots. One word returns one result
// word: status (tuser), the stored value when the key is found, the slot
// where probing stopped (zero when no free slot or key was found) and the
// occupancy. After reset a clearing pass writes every valid bit, during
// which no input word is taken. For each word the shared digit reducer
// reduces each hash in 16 folds of 4 bits, each probe is a read of the slot
// memory followed by a compare, and the result state then loads the output
// register. The engine takes one item at a time and is ready again in the
// cycle after that load; a finished result sits in the output register
// while the next word is accepted, and a result that finds the output
// register still full holds the engine until the receiver takes the
// waiting word.
module double_hash_table_engine_core
    import dhte_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // tdata, from bit 0: key[63:0], hash_primary[63:0], hash_step[63:0],
    // value[31:0]
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    // tuser: cmd (0 search, 1 insert)
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, from bit 0: found_value[31:0], slot_index[9:0],
    // occupancy[9:0], 4 zero bits
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    // tuser: status (0 hit, 1 miss, 2 inserted, 3 present, 4 full)
    output logic [STATUS_W-1:0]   m_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_RED_HP = 7'b0000100,
        S_RED_HS = 7'b0001000,
        S_PRB_RD = 7'b0010000,
        S_PRB_CK = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;

    // Item being worked on
    logic                  cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [HASH_W-1:0]     hs_reg, hs_next;

    // Probe state
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      stride_reg, stride_next;
    logic [IDX_W-1:0]      probe_cnt_reg, probe_cnt_next;
    logic [IDX_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    // Result of the current item
    status_t               res_status_reg, res_status_next;
    logic [VALUE_BITS-1:0] res_found_reg, res_found_next;
    logic [IDX_W-1:0]      res_where_reg, res_where_next;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [FOUND_W-1:0]    m_found_reg, m_found_next;
    logic [SLOT_W-1:0]     m_slot_reg, m_slot_next;
    logic [OCC_W-1:0]      m_occ_reg, m_occ_next;

    // Reducer and memory hookup
    logic                  red_start;
    logic [HASH_W-1:0]     red_operand;
    logic                  red_done;
    logic [IDX_W-1:0]      red_result;
    ram_ctrl_t             ram_ctrl;
    logic [IDX_W-1:0]      ram_addr;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic                  rd_valid;

    logic                  s_accept;
    logic                  out_free;
    logic [IDX_W:0]        step_sum;
    logic [IDX_W-1:0]      idx_step;
    logic [63:0]           val_in_ext;
    logic [63:0]           found_ext;
    logic [31:0]           slot_ext;
    logic [31:0]           occ_ext;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Keep only the low VALUE_BITS of the incoming value
    assign val_in_ext = 64'(s_axis_tdata[VAL_LSB +: VAL_IN_W]);

    // Next slot in the probe sequence: both terms are below TABLE_SLOTS
    always_comb begin
        step_sum = {1'b0, idx_reg} + {1'b0, stride_reg};
        if (step_sum >= (IDX_W + 1)'(TABLE_SLOTS)) begin
            step_sum = step_sum - (IDX_W + 1)'(TABLE_SLOTS);
        end
        idx_step = step_sum[IDX_W-1:0];
    end

    // Hash reducer: first hash straight off the bus, second from the hold reg
    assign red_start   = s_accept || ((state_reg == S_RED_HP) && red_done);
    assign red_operand = (state_reg == S_IDLE) ? s_axis_tdata[HP_LSB +: HASH_W] : hs_reg;

    assign ram_addr = (state_reg == S_CLEAR) ? clr_addr_reg : idx_reg;

    assign found_ext = 64'(res_found_reg);
    assign slot_ext  = 32'(res_where_reg);
    assign occ_ext   = 32'(count_reg);

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        hs_next         = hs_reg;
        idx_next        = idx_reg;
        stride_next     = stride_reg;
        probe_cnt_next  = probe_cnt_reg;
        clr_addr_next   = clr_addr_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_where_next  = res_where_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_found_next    = m_found_reg;
        m_slot_next     = m_slot_reg;
        m_occ_next      = m_occ_reg;
        ram_ctrl        = '0;

        // Drop the output word once taken
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                // Sweep every valid bit to zero after reset
                ram_ctrl.vld_we    = 1'b1;
                ram_ctrl.vld_wdata = 1'b0;
                clr_addr_next      = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(TABLE_SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    cmd_next   = s_axis_tuser;
                    key_next   = s_axis_tdata[KEY_LSB +: KEY_BITS];
                    val_next   = val_in_ext[VALUE_BITS-1:0];
                    hs_next    = s_axis_tdata[HS_LSB +: HASH_W];
                    state_next = S_RED_HP;
                end
            end
            S_RED_HP: begin
                if (red_done) begin
                    idx_next   = red_result;
                    state_next = S_RED_HS;
                end
            end
            S_RED_HS: begin
                if (red_done) begin
                    stride_next    = red_result;
                    probe_cnt_next = '0;
                    state_next     = S_PRB_RD;
                end
            end
            S_PRB_RD: begin
                ram_ctrl.rd_en = 1'b1;
                state_next     = S_PRB_CK;
            end
            S_PRB_CK: begin
                res_found_next = '0;
                if (!rd_valid) begin
                    // Empty slot ends the walk; an insert claims it
                    res_where_next = idx_reg;
                    state_next     = S_RESULT;
                    if (cmd_reg == CMD_INSERT) begin
                        ram_ctrl.kv_we     = 1'b1;
                        ram_ctrl.vld_we    = 1'b1;
                        ram_ctrl.vld_wdata = 1'b1;
                        count_next         = count_reg + CNT_W'(1);
                        res_status_next    = ST_INSERTED;
                    end else begin
                        res_status_next = ST_MISS;
                    end
                end else if (rd_key == key_reg) begin
                    res_where_next  = idx_reg;
                    res_found_next  = rd_value;
                    res_status_next = (cmd_reg == CMD_INSERT) ? ST_PRESENT : ST_HIT;
                    state_next      = S_RESULT;
                end else if (probe_cnt_reg == IDX_W'(TABLE_SLOTS - 1)) begin
                    // Whole sequence walked without a free slot or the key
                    res_where_next  = '0;
                    res_status_next = (cmd_reg == CMD_INSERT) ? ST_FULL : ST_MISS;
                    state_next      = S_RESULT;
                end else begin
                    idx_next       = idx_step;
                    probe_cnt_next = probe_cnt_reg + IDX_W'(1);
                    state_next     = S_PRB_RD;
                end
            end
            S_RESULT: begin
                // Hold until the output register is free
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_found_next  = found_ext[FOUND_W-1:0];
                    m_slot_next   = slot_ext[SLOT_W-1:0];
                    m_occ_next    = occ_ext[OCC_W-1:0];
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        hs_reg         <= hs_next;
        idx_reg        <= idx_next;
        stride_reg     <= stride_next;
        probe_cnt_reg  <= probe_cnt_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_where_reg  <= res_where_next;
        m_status_reg   <= m_status_next;
        m_found_reg    <= m_found_next;
        m_slot_reg     <= m_slot_next;
        m_occ_reg      <= m_occ_next;
    end

    dhte_modred #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_modred (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (red_start),
        .operand (red_operand),
        .done    (red_done),
        .result  (red_result)
    );

    dhte_slot_ram #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_slot_ram (
        .aclk     (aclk),
        .ctrl     (ram_ctrl),
        .addr     (ram_addr),
        .wr_key   (key_reg),
        .wr_value (val_reg),
        .rd_key   (rd_key),
        .rd_value (rd_value),
        .rd_valid (rd_valid)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {{(M_DATA_W - FOUND_W - SLOT_W - OCC_W){1'b0}},
                            m_occ_reg, m_slot_reg, m_found_reg};

endmodule
